// ===== src/spmj_pkg.sv =====
`default_nettype none

package spmj_pkg;

  // operation codes of an input transaction
  typedef logic [2:0] func_t;
  localparam func_t FUNC_INSERT   = 3'd0;
  localparam func_t FUNC_TRUNCATE = 3'd1;
  localparam func_t FUNC_INTERSECT = 3'd2;
  localparam func_t FUNC_SYMDIFF  = 3'd3;
  localparam func_t FUNC_SELECT   = 3'd4;

  // kinds of a result transaction
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_OK   = 2'd0;
  localparam kind_t KIND_DUP  = 2'd1;
  localparam kind_t KIND_FULL = 2'd2;
  localparam kind_t KIND_ROW  = 2'd3;

  // table select codes
  localparam logic TABLE_A = 1'b0;
  localparam logic TABLE_B = 1'b1;

endpackage

`default_nettype wire

// ===== src/spmj_ram.sv =====
`default_nettype none

module spmj_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/sorted_pair_table_merge_join.sv =====
`default_nettype none

// Two sorted (key, payload) tables A and B with insert, truncate, select,
// intersection and symmetric difference. A command is taken when start is
// high and busy is low; for insert, select and the merge queries busy then
// stays high until the final status result of the command has been produced.
// Results appear at most one per cycle with out_valid high for exactly one
// cycle and must be captured then, since the block has no way to be held off.
// Each table sits in a RAM with one registered read port, and one sequencer
// with one shared key comparator walks the entries one per cycle: an insert
// searches up to the insert point, shifts the rest up and writes the new
// entry, or stops at the search on a duplicate or full table. Truncate and
// unknown codes decide their status in the accept cycle and never raise busy.
// Each result leaves the output register in the cycle after the sequencer
// decides it, so a new command may be taken while the last status is still
// on the outputs.
module sorted_pair_table_merge_join #(
  parameter int TABLE_DEPTH  = 16,
  parameter int KEY_BITS     = 32,
  parameter int PAYLOAD_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_func,
  input  wire logic        in_table_sel,
  input  wire logic [31:0] in_key,
  input  wire logic [31:0] in_payload,
  output logic             out_valid,
  output logic [1:0]       out_kind,
  output logic [31:0]      out_row_key,
  output logic [31:0]      out_left_payload,
  output logic [31:0]      out_right_payload,
  output logic             out_left_present,
  output logic             out_right_present,
  output logic             out_last
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = KEY_BITS + PAYLOAD_BITS;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INS   = 3'd1;
  localparam logic [2:0] ST_SHIFT = 3'd2;
  localparam logic [2:0] ST_PLACE = 3'd3;
  localparam logic [2:0] ST_SEL   = 3'd4;
  localparam logic [2:0] ST_MRG   = 3'd5;

  logic [2:0]              state_r, state_nxt;
  logic [CW-1:0]           ia_r, ia_nxt;
  logic [CW-1:0]           ib_r, ib_nxt;
  logic [CW-1:0]           pos_r, pos_nxt;
  logic [CW-1:0]           cnt_a_r, cnt_a_nxt;
  logic [CW-1:0]           cnt_b_r, cnt_b_nxt;
  logic                    sel_r, sel_nxt;
  logic                    shared_r, shared_nxt;
  logic [KEY_BITS-1:0]     key_r, key_nxt;
  logic [PAYLOAD_BITS-1:0] pay_r, pay_nxt;

  logic                    out_valid_r, out_valid_nxt;
  spmj_pkg::kind_t         out_kind_r, out_kind_nxt;
  logic [31:0]             out_row_key_r, out_row_key_nxt;
  logic [31:0]             out_lpay_r, out_lpay_nxt;
  logic [31:0]             out_rpay_r, out_rpay_nxt;
  logic                    out_lpres_r, out_lpres_nxt;
  logic                    out_rpres_r, out_rpres_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [EW-1:0]           rdata_a, rdata_b, wdata;
  logic [AW-1:0]           raddr_a, raddr_b, waddr;
  logic                    we;

  logic [KEY_BITS-1:0]     key_a, key_b, key_s;
  logic [PAYLOAD_BITS-1:0] pay_a, pay_b, pay_s;
  logic [63:0]             key_a64, key_b64, key_s64, key_r64, in_key64, in_pay64;
  logic [63:0]             pay_a64, pay_b64, pay_s64;
  logic [CW-1:0]           cnt_s;
  logic [KEY_BITS-1:0]     cmp_lhs, cmp_rhs;
  logic                    cmp_lt, cmp_eq;

  // table storage
  spmj_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (we && (sel_r == spmj_pkg::TABLE_A)),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  spmj_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (we && (sel_r == spmj_pkg::TABLE_B)),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  // entry fields and widened copies for the 32 bit result ports
  assign key_a   = rdata_a[EW-1:PAYLOAD_BITS];
  assign pay_a   = rdata_a[PAYLOAD_BITS-1:0];
  assign key_b   = rdata_b[EW-1:PAYLOAD_BITS];
  assign pay_b   = rdata_b[PAYLOAD_BITS-1:0];
  assign key_s   = sel_r ? key_b : key_a;
  assign pay_s   = sel_r ? pay_b : pay_a;
  assign cnt_s   = sel_r ? cnt_b_r : cnt_a_r;
  assign key_a64 = 64'(key_a);
  assign key_b64 = 64'(key_b);
  assign key_s64 = 64'(key_s);
  assign key_r64 = 64'(key_r);
  assign pay_a64 = 64'(pay_a);
  assign pay_b64 = 64'(pay_b);
  assign pay_s64 = 64'(pay_s);
  assign in_key64 = 64'(in_key);
  assign in_pay64 = 64'(in_payload);

  // shared key comparator
  assign cmp_lhs = (state_r == ST_MRG) ? key_a : key_s;
  assign cmp_rhs = (state_r == ST_MRG) ? key_b : key_r;
  assign cmp_lt  = cmp_lhs < cmp_rhs;
  assign cmp_eq  = cmp_lhs == cmp_rhs;

  // read addresses follow the next indices, so read data matches the index
  assign raddr_a = ia_nxt[AW-1:0];
  assign raddr_b = (state_nxt == ST_MRG) ? ib_nxt[AW-1:0] : ia_nxt[AW-1:0];

  // sequencer
  always_comb begin
    logic a_v, b_v, take_a, take_b;
    state_nxt       = state_r;
    ia_nxt          = ia_r;
    ib_nxt          = ib_r;
    pos_nxt         = pos_r;
    cnt_a_nxt       = cnt_a_r;
    cnt_b_nxt       = cnt_b_r;
    sel_nxt         = sel_r;
    shared_nxt      = shared_r;
    key_nxt         = key_r;
    pay_nxt         = pay_r;
    out_valid_nxt   = 1'b0;
    out_kind_nxt    = spmj_pkg::KIND_OK;
    out_row_key_nxt = '0;
    out_lpay_nxt    = '0;
    out_rpay_nxt    = '0;
    out_lpres_nxt   = 1'b0;
    out_rpres_nxt   = 1'b0;
    out_last_nxt    = 1'b0;
    we              = 1'b0;
    waddr           = pos_r[AW-1:0];
    wdata           = {key_r, pay_r};
    a_v             = ia_r < cnt_a_r;
    b_v             = ib_r < cnt_b_r;
    take_a          = !b_v || (a_v && cmp_lt);
    take_b          = !a_v || (b_v && !cmp_lt && !cmp_eq);

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          sel_nxt    = in_table_sel;
          key_nxt    = in_key64[KEY_BITS-1:0];
          pay_nxt    = in_pay64[PAYLOAD_BITS-1:0];
          ia_nxt     = '0;
          ib_nxt     = '0;
          shared_nxt = (in_func == spmj_pkg::FUNC_INTERSECT);
          case (in_func)
            spmj_pkg::FUNC_INSERT: state_nxt = ST_INS;
            spmj_pkg::FUNC_SELECT: state_nxt = ST_SEL;
            spmj_pkg::FUNC_INTERSECT, spmj_pkg::FUNC_SYMDIFF: state_nxt = ST_MRG;
            spmj_pkg::FUNC_TRUNCATE: begin
              if (in_table_sel == spmj_pkg::TABLE_B) begin
                cnt_b_nxt = '0;
              end else begin
                cnt_a_nxt = '0;
              end
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
            end
          endcase
        end
      end

      // search for the first entry not below the new key
      ST_INS: begin
        if ((ia_r < cnt_s) && cmp_lt) begin
          ia_nxt = ia_r + ONE_C;
        end else if ((ia_r < cnt_s) && cmp_eq) begin
          out_valid_nxt   = 1'b1;
          out_last_nxt    = 1'b1;
          out_kind_nxt    = spmj_pkg::KIND_DUP;
          out_row_key_nxt = key_r64[31:0];
          state_nxt       = ST_IDLE;
        end else if (cnt_s == DEPTH_C) begin
          out_valid_nxt   = 1'b1;
          out_last_nxt    = 1'b1;
          out_kind_nxt    = spmj_pkg::KIND_FULL;
          out_row_key_nxt = key_r64[31:0];
          state_nxt       = ST_IDLE;
        end else begin
          pos_nxt = ia_r;
          if (ia_r == cnt_s) begin
            state_nxt = ST_PLACE;
          end else begin
            ia_nxt    = cnt_s - ONE_C;
            state_nxt = ST_SHIFT;
          end
        end
      end

      // move entries up by one, top first
      ST_SHIFT: begin
        we    = 1'b1;
        waddr = AW'(ia_r + ONE_C);
        wdata = sel_r ? rdata_b : rdata_a;
        if (ia_r == pos_r) begin
          state_nxt = ST_PLACE;
        end else begin
          ia_nxt = ia_r - ONE_C;
        end
      end

      // write the new entry into the gap
      ST_PLACE: begin
        we = 1'b1;
        if (sel_r == spmj_pkg::TABLE_B) begin
          cnt_b_nxt = cnt_b_r + ONE_C;
        end else begin
          cnt_a_nxt = cnt_a_r + ONE_C;
        end
        out_valid_nxt = 1'b1;
        out_last_nxt  = 1'b1;
        state_nxt     = ST_IDLE;
      end

      // list one table in key order
      ST_SEL: begin
        out_valid_nxt = 1'b1;
        if (ia_r < cnt_s) begin
          out_kind_nxt    = spmj_pkg::KIND_ROW;
          out_row_key_nxt = key_s64[31:0];
          out_lpay_nxt    = pay_s64[31:0];
          out_lpres_nxt   = 1'b1;
          ia_nxt          = ia_r + ONE_C;
        end else begin
          out_last_nxt = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end

      // merge walk over both tables
      ST_MRG: begin
        if (!a_v && !b_v) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (!take_a && !take_b) begin
          if (shared_r) begin
            out_valid_nxt   = 1'b1;
            out_kind_nxt    = spmj_pkg::KIND_ROW;
            out_row_key_nxt = key_a64[31:0];
            out_lpay_nxt    = pay_a64[31:0];
            out_rpay_nxt    = pay_b64[31:0];
            out_lpres_nxt   = 1'b1;
            out_rpres_nxt   = 1'b1;
          end
          ia_nxt = ia_r + ONE_C;
          ib_nxt = ib_r + ONE_C;
        end else if (take_a) begin
          if (!shared_r) begin
            out_valid_nxt   = 1'b1;
            out_kind_nxt    = spmj_pkg::KIND_ROW;
            out_row_key_nxt = key_a64[31:0];
            out_lpay_nxt    = pay_a64[31:0];
            out_lpres_nxt   = 1'b1;
          end
          ia_nxt = ia_r + ONE_C;
        end else begin
          if (!shared_r) begin
            out_valid_nxt   = 1'b1;
            out_kind_nxt    = spmj_pkg::KIND_ROW;
            out_row_key_nxt = key_b64[31:0];
            out_rpay_nxt    = pay_b64[31:0];
            out_rpres_nxt   = 1'b1;
          end
          ib_nxt = ib_r + ONE_C;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      out_valid_r <= 1'b0;
      ia_r        <= '0;
      ib_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      out_valid_r <= out_valid_nxt;
      ia_r        <= ia_nxt;
      ib_r        <= ib_nxt;
    end
  end

  // transaction payload and result registers
  always_ff @(posedge clk) begin
    pos_r         <= pos_nxt;
    sel_r         <= sel_nxt;
    shared_r      <= shared_nxt;
    key_r         <= key_nxt;
    pay_r         <= pay_nxt;
    out_kind_r    <= out_kind_nxt;
    out_row_key_r <= out_row_key_nxt;
    out_lpay_r    <= out_lpay_nxt;
    out_rpay_r    <= out_rpay_nxt;
    out_lpres_r   <= out_lpres_nxt;
    out_rpres_r   <= out_rpres_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_row_key       = out_row_key_r;
  assign out_left_payload  = out_lpay_r;
  assign out_right_payload = out_rpay_r;
  assign out_left_present  = out_lpres_r;
  assign out_right_present = out_rpres_r;
  assign out_last          = out_last_r;

endmodule

`default_nettype wire

// ===== tb/sv/tb_sorted_pair_table_merge_join.sv =====
`timescale 1ns / 1ps

module tb_sorted_pair_table_merge_join;

  localparam int DEPTH         = 16;
  localparam int POOL_SIZE     = 24;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS  = 100;
  localparam int LAST_ITEMS    = 20;

  // codes that the block answers with a bare ok status
  localparam spmj_pkg::func_t FUNC_UNKNOWN_LO  = 3'd5;
  localparam spmj_pkg::func_t FUNC_UNKNOWN_MID = 3'd6;
  localparam spmj_pkg::func_t FUNC_UNKNOWN_HI  = 3'd7;

  // one expected result transaction
  typedef struct {
    spmj_pkg::kind_t kind;
    logic [31:0]     row_key;
    logic [31:0]     left_pay;
    logic [31:0]     right_pay;
    logic            left_pres;
    logic            right_pres;
    logic            is_last;
  } join_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_func;
  logic        in_table_sel;
  logic [31:0] in_key;
  logic [31:0] in_payload;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [31:0] out_row_key;
  logic [31:0] out_left_payload;
  logic [31:0] out_right_payload;
  logic        out_left_present;
  logic        out_right_present;
  logic        out_last;

  // shadow copy of both tables, indexed by table select
  logic [31:0] tbl_keys [2][DEPTH];
  logic [31:0] tbl_pays [2][DEPTH];
  int          tbl_fill [2];

  join_row_t   expected_rows [$];
  logic [31:0] key_pool [POOL_SIZE];
  int          fail_count   = 0;
  int          stall_cycles = 0;
  int          sent_count   = 0;
  bit          gaps_on      = 1'b1;

  sorted_pair_table_merge_join #(
    .TABLE_DEPTH (DEPTH),
    .KEY_BITS    (32),
    .PAYLOAD_BITS(32)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_table_sel     (in_table_sel),
    .in_key           (in_key),
    .in_payload       (in_payload),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_row_key      (out_row_key),
    .out_left_payload (out_left_payload),
    .out_right_payload(out_right_payload),
    .out_left_present (out_left_present),
    .out_right_present(out_right_present),
    .out_last         (out_last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void push_row(spmj_pkg::kind_t kd, logic [31:0] k, logic [31:0] lp,
                                   logic [31:0] rp, logic lv, logic rv, logic lst);
    join_row_t row;
    row.kind       = kd;
    row.row_key    = k;
    row.left_pay   = lp;
    row.right_pay  = rp;
    row.left_pres  = lv;
    row.right_pres = rv;
    row.is_last    = lst;
    expected_rows  = {expected_rows, row};
  endfunction

  // merge walk over both tables: shared keys or keys in one table only
  function automatic void predict_merge(bit shared);
    int ia;
    int ib;
    bit take_a;
    bit take_b;
    ia = 0;
    ib = 0;
    while (ia < tbl_fill[spmj_pkg::TABLE_A] || ib < tbl_fill[spmj_pkg::TABLE_B]) begin
      take_a = (ib >= tbl_fill[spmj_pkg::TABLE_B]) ||
               (ia < tbl_fill[spmj_pkg::TABLE_A] &&
                tbl_keys[spmj_pkg::TABLE_A][ia] < tbl_keys[spmj_pkg::TABLE_B][ib]);
      take_b = (ia >= tbl_fill[spmj_pkg::TABLE_A]) ||
               (ib < tbl_fill[spmj_pkg::TABLE_B] &&
                tbl_keys[spmj_pkg::TABLE_B][ib] < tbl_keys[spmj_pkg::TABLE_A][ia]);
      if (!take_a && !take_b) begin
        if (shared)
          push_row(spmj_pkg::KIND_ROW, tbl_keys[spmj_pkg::TABLE_A][ia],
                   tbl_pays[spmj_pkg::TABLE_A][ia], tbl_pays[spmj_pkg::TABLE_B][ib],
                   1'b1, 1'b1, 1'b0);
        ia++;
        ib++;
      end else if (take_a) begin
        if (!shared)
          push_row(spmj_pkg::KIND_ROW, tbl_keys[spmj_pkg::TABLE_A][ia],
                   tbl_pays[spmj_pkg::TABLE_A][ia], '0, 1'b1, 1'b0, 1'b0);
        ia++;
      end else begin
        if (!shared)
          push_row(spmj_pkg::KIND_ROW, tbl_keys[spmj_pkg::TABLE_B][ib], '0,
                   tbl_pays[spmj_pkg::TABLE_B][ib], 1'b0, 1'b1, 1'b0);
        ib++;
      end
    end
    push_row(spmj_pkg::KIND_OK, '0, '0, '0, 1'b0, 1'b0, 1'b1);
  endfunction

  // expected results of one accepted command, with the table update
  function automatic void predict_cmd(spmj_pkg::func_t f, logic sel, logic [31:0] k,
                                      logic [31:0] p);
    int pos;
    int i;
    pos = 0;
    case (f)
      spmj_pkg::FUNC_INSERT: begin
        while (pos < tbl_fill[sel] && tbl_keys[sel][pos] < k) pos++;
        if (pos < tbl_fill[sel] && tbl_keys[sel][pos] == k) begin
          push_row(spmj_pkg::KIND_DUP, k, '0, '0, 1'b0, 1'b0, 1'b1);
        end else if (tbl_fill[sel] >= DEPTH) begin
          push_row(spmj_pkg::KIND_FULL, k, '0, '0, 1'b0, 1'b0, 1'b1);
        end else begin
          for (i = tbl_fill[sel]; i > pos; i--) begin
            tbl_keys[sel][i] = tbl_keys[sel][i - 1];
            tbl_pays[sel][i] = tbl_pays[sel][i - 1];
          end
          tbl_keys[sel][pos] = k;
          tbl_pays[sel][pos] = p;
          tbl_fill[sel]++;
          push_row(spmj_pkg::KIND_OK, '0, '0, '0, 1'b0, 1'b0, 1'b1);
        end
      end
      spmj_pkg::FUNC_TRUNCATE: begin
        tbl_fill[sel] = 0;
        push_row(spmj_pkg::KIND_OK, '0, '0, '0, 1'b0, 1'b0, 1'b1);
      end
      spmj_pkg::FUNC_INTERSECT: predict_merge(1'b1);
      spmj_pkg::FUNC_SYMDIFF:   predict_merge(1'b0);
      spmj_pkg::FUNC_SELECT: begin
        for (i = 0; i < tbl_fill[sel]; i++)
          push_row(spmj_pkg::KIND_ROW, tbl_keys[sel][i], tbl_pays[sel][i], '0,
                   1'b1, 1'b0, 1'b0);
        push_row(spmj_pkg::KIND_OK, '0, '0, '0, 1'b0, 1'b0, 1'b1);
      end
      default: push_row(spmj_pkg::KIND_OK, '0, '0, '0, 1'b0, 1'b0, 1'b1);
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endfunction

  // result check, command prediction and stall count at each edge
  always @(posedge clk) begin : result_check
    join_row_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_rows.size() == 0) begin
          $error("result with nothing expected: kind %0d key %h", out_kind, out_row_key);
          fail_count++;
        end else begin
          want = expected_rows.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_kind));
          check_field("row_key", want.row_key, out_row_key);
          check_field("left_payload", want.left_pay, out_left_payload);
          check_field("right_payload", want.right_pay, out_right_payload);
          check_field("left_present", 32'(want.left_pres), 32'(out_left_present));
          check_field("right_present", 32'(want.right_pres), 32'(out_right_present));
          check_field("last", 32'(want.is_last), 32'(out_last));
        end
      end
      if (start && !busy)
        predict_cmd(in_func, in_table_sel, in_key, in_payload);
      if (out_valid || (start && !busy))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
    end
  end

  // watchdog on cycles without any transaction
  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  // hold one command on the inputs until the block takes it
  task automatic send_cmd(spmj_pkg::func_t f, logic sel, logic [31:0] k, logic [31:0] p);
    start        <= 1'b1;
    in_func      <= f;
    in_table_sel <= sel;
    in_key       <= k;
    in_payload   <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_count++;
  endtask

  // random burst of idle cycles with noise on the fields
  task automatic maybe_gap();
    int n;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      n            = $urandom_range(1, 12);
      start        <= 1'b0;
      in_func      <= 3'($urandom);
      in_table_sel <= 1'($urandom);
      in_key       <= $urandom;
      in_payload   <= $urandom;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic issue(spmj_pkg::func_t f, logic sel, logic [31:0] k, logic [31:0] p);
    maybe_gap();
    send_cmd(f, sel, k, p);
  endtask

  // sender holds off until every expected result has come back
  task automatic wait_drain();
    start <= 1'b0;
    @(posedge clk);
    while (expected_rows.size() != 0) @(posedge clk);
  endtask

  // keys mostly from a shared pool so that the tables overlap
  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 3) == 0)
      return $urandom;
    return key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  task automatic random_op();
    int   r;
    logic sel;
    r   = $urandom_range(0, 99);
    sel = 1'($urandom_range(0, 1));
    if (r < 60)
      issue(spmj_pkg::FUNC_INSERT, sel, pick_key(), $urandom);
    else if (r < 68)
      issue(spmj_pkg::FUNC_SELECT, sel, $urandom, $urandom);
    else if (r < 78)
      issue(spmj_pkg::FUNC_INTERSECT, sel, $urandom, $urandom);
    else if (r < 88)
      issue(spmj_pkg::FUNC_SYMDIFF, sel, $urandom, $urandom);
    else if (r < 93)
      issue(spmj_pkg::FUNC_TRUNCATE, sel, $urandom, $urandom);
    else
      issue(spmj_pkg::func_t'($urandom_range(FUNC_UNKNOWN_LO, FUNC_UNKNOWN_HI)), sel,
            $urandom, $urandom);
  endtask

  // extreme keys and payloads, duplicate refusal, listing of both tables
  task automatic test_insert_and_select();
    issue(spmj_pkg::FUNC_SELECT, spmj_pkg::TABLE_A, '1, '1);
    issue(spmj_pkg::FUNC_INSERT, spmj_pkg::TABLE_A, 32'h0000_0000, 32'hFFFF_FFFF);
    issue(spmj_pkg::FUNC_INSERT, spmj_pkg::TABLE_A, 32'hFFFF_FFFF, 32'h0000_0000);
    issue(spmj_pkg::FUNC_INSERT, spmj_pkg::TABLE_A, 32'h8000_0000, 32'hA5A5_A5A5);
    issue(spmj_pkg::FUNC_INSERT, spmj_pkg::TABLE_A, 32'h8000_0000, 32'h0000_0001);
    issue(spmj_pkg::FUNC_INSERT, spmj_pkg::TABLE_B, 32'h8000_0000, 32'h5A5A_5A5A);
    issue(spmj_pkg::FUNC_INSERT, spmj_pkg::TABLE_B, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    issue(spmj_pkg::FUNC_SELECT, spmj_pkg::TABLE_A, '0, '0);
    issue(spmj_pkg::FUNC_SELECT, spmj_pkg::TABLE_B, '0, '0);
  endtask

  // both merge queries with table select ignored, also on truncated tables
  task automatic test_merge_queries();
    issue(spmj_pkg::FUNC_INTERSECT, spmj_pkg::TABLE_B, '1, '1);
    issue(spmj_pkg::FUNC_SYMDIFF, spmj_pkg::TABLE_A, '0, '0);
    issue(spmj_pkg::FUNC_TRUNCATE, spmj_pkg::TABLE_B, '0, '0);
    issue(spmj_pkg::FUNC_SYMDIFF, spmj_pkg::TABLE_B, '0, '0);
    issue(spmj_pkg::FUNC_TRUNCATE, spmj_pkg::TABLE_A, '0, '0);
    issue(spmj_pkg::FUNC_INTERSECT, spmj_pkg::TABLE_A, '0, '0);
  endtask

  // undefined function codes answer with a plain ok
  task automatic test_unknown_codes();
    issue(FUNC_UNKNOWN_LO, spmj_pkg::TABLE_A, '1, '1);
    issue(FUNC_UNKNOWN_MID, spmj_pkg::TABLE_B, '0, '1);
    issue(FUNC_UNKNOWN_HI, spmj_pkg::TABLE_B, '1, '0);
  endtask

  // fill one table past its depth, then a duplicate on the full table
  task automatic test_table_full();
    logic sel;
    sel = 1'($urandom_range(0, 1));
    issue(spmj_pkg::FUNC_TRUNCATE, sel, '0, '0);
    repeat (DEPTH + 2) issue(spmj_pkg::FUNC_INSERT, sel, $urandom, $urandom);
    issue(spmj_pkg::FUNC_INSERT, sel, tbl_keys[sel][$urandom_range(0, DEPTH - 1)],
          $urandom);
    issue(spmj_pkg::FUNC_SELECT, sel, '0, '0);
    issue(spmj_pkg::FUNC_SYMDIFF, ~sel, '0, '0);
  endtask

  // sessions of random commands, each closed by both merge queries
  task automatic test_random_sessions();
    bit drained;
    drained = 1'b0;
    while (sent_count < RANDOM_ITEMS) begin
      repeat ($urandom_range(4, 16)) random_op();
      issue(spmj_pkg::FUNC_INTERSECT, 1'($urandom), $urandom, $urandom);
      issue(spmj_pkg::FUNC_SYMDIFF, 1'($urandom), $urandom, $urandom);
      if (!drained || $urandom_range(0, 3) == 0) begin
        wait_drain();
        drained = 1'b1;
      end
    end
  endtask

  // closing stretch with no idle cycles on the sender
  task automatic test_back_to_back();
    gaps_on = 1'b0;
    repeat (LAST_ITEMS) random_op();
    issue(spmj_pkg::FUNC_INTERSECT, spmj_pkg::TABLE_A, '0, '0);
    issue(spmj_pkg::FUNC_SYMDIFF, spmj_pkg::TABLE_B, '0, '0);
  endtask

  // stimulus sequence
  initial begin
    start        <= 1'b0;
    in_func      <= spmj_pkg::FUNC_INSERT;
    in_table_sel <= spmj_pkg::TABLE_A;
    in_key       <= '0;
    in_payload   <= '0;
    rst_n        <= 1'b0;
    tbl_fill[spmj_pkg::TABLE_A] = 0;
    tbl_fill[spmj_pkg::TABLE_B] = 0;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_insert_and_select();
    test_merge_queries();
    test_unknown_codes();
    test_table_full();
    test_random_sessions();
    test_back_to_back();

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== sorted_pair_table_merge_join.f =====
src/spmj_pkg.sv
src/spmj_ram.sv
src/sorted_pair_table_merge_join.sv
tb/sv/tb_sorted_pair_table_merge_join.sv
